>>> hw/rtl/mtb_pkg.sv
// shared types and constants for the mertens table builder
// no dependencies; used by mtb_div and mertens_table_builder_unit
`default_nettype none

package mtb_pkg;

  // field widths of the request and result
  localparam int ARG_W = 17;
  localparam int VAL_W = 16;
  localparam int ST_W  = 2;

  // default number of table entries
  localparam int TABLE_DEPTH_DEF = 65536;

  // running sum holds up to 2^ARG_W terms of VAL_W bits
  localparam int ACC_W = VAL_W + ARG_W;

  // saturation bounds of a result value
  localparam int VAL_MAX = 32767;
  localparam int VAL_MIN = -32768;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_COMPUTED = 2'd0,
    ST_READ     = 2'd1,
    ST_ERROR    = 2'd2
  } status_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [ARG_W-1:0] dividend;
    logic [ARG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ARG_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/mertens_table_builder_unit.sv
// top level of the mertens table builder: sequencer, table memory, accumulator
// depends on mtb_pkg and mtb_div
`default_nettype none

// Takes one argument n per request (start high while busy is low) and gives
// exactly one result, shown for a single cycle with out_valid high; the
// receiver cannot stall it, so it must take every strobe. If n is the next
// argument not yet in the table, M(n) is computed from stored entries with
// one shared divider that yields two quotient bits per cycle: n/3 first, then
// n/i for i = 2 .. floor(n/3), one division after another. A smaller n is
// read back from the table; an argument that is zero, beyond the table or
// ahead of order gives an error result in the next cycle and busy never
// rises. M(1) is preset, so there is no clearing pass after reset and the
// block takes requests at once.
module mertens_table_builder_unit #(
  parameter int TABLE_DEPTH = mtb_pkg::TABLE_DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire         [mtb_pkg::ARG_W-1:0]    in_arg_n,
  output logic                                out_valid,
  output logic        [mtb_pkg::ARG_W-1:0]    out_arg_echo,
  output logic signed [mtb_pkg::VAL_W-1:0]    out_mertens_value,
  output logic        [mtb_pkg::ST_W-1:0]     out_status
);
  import mtb_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NA_W  = IDX_W + 1;
  localparam int CMP_W = (ARG_W > NA_W) ? ARG_W : NA_W;
  localparam int FIN_W = ACC_W + 1;
  localparam int LIM_DIVISOR = 3;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LIM   = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_SUM   = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_RDB   = 7'b1000000
  } state_t;

  state_t                    state_r;
  state_t                    state_nxt;
  logic [NA_W-1:0]           next_arg_r;
  logic [ARG_W-1:0]          n_r;
  logic [ARG_W-1:0]          lim_r;
  logic [ARG_W-1:0]          i_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      rd_pend_r;
  logic                      rd_zero_r;
  logic signed [VAL_W-1:0]   rd_data_r;
  logic                      out_valid_r;
  logic [ARG_W-1:0]          out_arg_r;
  logic signed [VAL_W-1:0]   out_val_r;
  status_t                   out_status_r;

  logic signed [VAL_W-1:0]   mem [TABLE_DEPTH];

  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  logic                      accept;
  logic [CMP_W-1:0]          n_c;
  logic [CMP_W-1:0]          na_c;
  logic                      is_err;
  logic                      is_rd;
  logic                      rd_en;
  logic [ARG_W-1:0]          rd_src;
  logic [CMP_W-1:0]          rd_addr_w;
  logic [IDX_W-1:0]          rd_addr;
  logic                      rd_zero;
  logic                      wr_en;
  logic [CMP_W-1:0]          wr_addr_w;
  logic [IDX_W-1:0]          wr_addr;
  logic signed [VAL_W-1:0]   mem_val;
  logic [ARG_W-1:0]          half_w;
  logic signed [ACC_W-1:0]   addend;
  logic signed [FIN_W-1:0]   fin_w;
  logic signed [VAL_W-1:0]   fin_val;

  // request classification against the next uncomputed argument
  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign n_c    = CMP_W'(in_arg_n);
  assign na_c   = CMP_W'(next_arg_r);
  assign is_err = (n_c == '0) || (n_c > CMP_W'(TABLE_DEPTH)) || (n_c > na_c);
  assign is_rd  = !is_err && (n_c < na_c);

  // sequencer: n/3 for the bound, then one division and one table read per term
  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = n_r;
    div_req.divisor  = i_r + ARG_W'(1);
    rd_en            = 1'b0;
    wr_en            = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !is_err) begin
          if (is_rd) begin
            rd_en     = 1'b1;
            state_nxt = S_RDB;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = in_arg_n;
            div_req.divisor  = ARG_W'(LIM_DIVISOR);
            state_nxt        = S_LIM;
          end
        end
      end
      S_LIM: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient < ARG_W'(2)) begin
            state_nxt = S_SUM;
          end else begin
            div_req.start   = 1'b1;
            div_req.divisor = ARG_W'(2);
            state_nxt       = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          rd_en = 1'b1;
          if (i_r == lim_r) begin
            state_nxt = S_DRAIN;
          end else begin
            div_req.start = 1'b1;
          end
        end
      end
      S_DRAIN: state_nxt = S_SUM;
      S_SUM:   state_nxt = S_FIN;
      S_FIN: begin
        wr_en     = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RDB:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // table address: argument minus one; entry zero is never written, M(1) = 1 is put in its place on a read
  assign rd_src    = (state_r == S_IDLE) ? in_arg_n : div_rsp.quotient;
  assign rd_addr_w = CMP_W'(rd_src) - CMP_W'(1);
  assign rd_addr   = rd_addr_w[IDX_W-1:0];
  assign rd_zero   = (rd_src == ARG_W'(1));
  assign wr_addr_w = CMP_W'(n_r) - CMP_W'(1);
  assign wr_addr   = wr_addr_w[IDX_W-1:0];
  assign mem_val   = rd_zero_r ? VAL_W'(1) : rd_data_r;

  // final value: 1 - (sum + floor((n+1)/2)), saturated
  assign half_w = ARG_W'((ARG_W + 1)'(n_r) + (ARG_W + 1)'(1) >> 1);
  assign addend = rd_pend_r ? ACC_W'(mem_val) : ACC_W'(half_w);
  assign fin_w  = FIN_W'(1) - FIN_W'(acc_r);

  always_comb begin
    priority if (fin_w > FIN_W'(VAL_MAX)) begin
      fin_val = VAL_W'(VAL_MAX);
    end else if (fin_w < FIN_W'(VAL_MIN)) begin
      fin_val = VAL_W'(VAL_MIN);
    end else begin
      fin_val = VAL_W'(fin_w);
    end
  end

  mtb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= fin_val;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_zero_r <= rd_zero;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_arg_r  <= NA_W'(2);
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_en && (state_r == S_DIV);
      out_valid_r <= (accept && is_err) || (state_r == S_RDB) || (state_r == S_FIN);
      if (state_r == S_FIN) begin
        next_arg_r <= NA_W'(CMP_W'(n_r) + CMP_W'(1));
      end
    end
  end

  // working registers and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      n_r   <= in_arg_n;
      acc_r <= '0;
    end else if (rd_pend_r || (state_r == S_SUM)) begin
      acc_r <= acc_r + addend;
    end
    if ((state_r == S_LIM) && div_rsp.done) begin
      lim_r <= div_rsp.quotient;
      i_r   <= ARG_W'(2);
    end else if ((state_r == S_DIV) && div_rsp.done && (i_r != lim_r)) begin
      i_r <= i_r + ARG_W'(1);
    end
    if (accept && is_err) begin
      out_arg_r    <= in_arg_n;
      out_val_r    <= '0;
      out_status_r <= ST_ERROR;
    end else if (state_r == S_RDB) begin
      out_arg_r    <= n_r;
      out_val_r    <= mem_val;
      out_status_r <= ST_READ;
    end else if (state_r == S_FIN) begin
      out_arg_r    <= n_r;
      out_val_r    <= fin_val;
      out_status_r <= ST_COMPUTED;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_arg_echo      = out_arg_r;
  assign out_mertens_value = out_val_r;
  assign out_status        = out_status_r;

`ifndef NO_ASSERTIONS
  // every request gives an error at once or makes the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid || busy))
    else $error("request neither answered nor started");

  // a computed result moves the next argument just past it
  a_next_arg_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_COMPUTED)) |->
      (CMP_W'(next_arg_r) == CMP_W'(out_arg_echo) + CMP_W'(1)))
    else $error("next argument out of step with computed result");

  // error results carry a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_ERROR)) |-> (out_mertens_value == '0))
    else $error("error result with nonzero value");

  // a term is only summed after a read issued by the division loop
  a_pend_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r == S_DIV))
    else $error("pending term without a loop read");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/mtb_div.sv
// iterative unsigned divider, two quotient bits per cycle
// depends on mtb_pkg for widths and the request/response structs
`default_nettype none

module mtb_div (
  input  wire               clk,
  input  wire               rst_n,
  input  mtb_pkg::div_req_t req,
  output mtb_pkg::div_rsp_t rsp
);
  import mtb_pkg::*;

  localparam int PAD_W = 2 * ((ARG_W + 1) / 2);
  localparam int STEPS = PAD_W / 2;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ARG_W-1:0] rem_r;
  logic [ARG_W-1:0] dsr_r;
  logic [PAD_W-1:0] dvd_r;

  logic [ARG_W:0]   sh0;
  logic [ARG_W:0]   sh1;
  logic             ge0;
  logic             ge1;
  logic [ARG_W-1:0] rem_mid;
  logic [ARG_W-1:0] rem_nxt;
  logic [PAD_W-1:0] dvd_mid;
  logic [PAD_W-1:0] dvd_nxt;

  // two restoring steps: shift in a dividend bit, subtract when it fits
  always_comb begin
    sh0     = {rem_r, dvd_r[PAD_W-1]};
    ge0     = (sh0 >= {1'b0, dsr_r});
    rem_mid = ge0 ? ARG_W'(sh0 - {1'b0, dsr_r}) : sh0[ARG_W-1:0];
    dvd_mid = {dvd_r[PAD_W-2:0], ge0};
    sh1     = {rem_mid, dvd_mid[PAD_W-1]};
    ge1     = (sh1 >= {1'b0, dsr_r});
    rem_nxt = ge1 ? ARG_W'(sh1 - {1'b0, dsr_r}) : sh1[ARG_W-1:0];
    dvd_nxt = {dvd_mid[PAD_W-2:0], ge1};
  end

  // control: busy while stepping, done pulse after the last step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: the dividend register fills with quotient bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dsr_r <= req.divisor;
      dvd_r <= PAD_W'(req.dividend);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r[ARG_W-1:0];

`ifndef NO_ASSERTIONS
  // a new division never cuts into one in flight
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  // done only follows a running division
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a division");

  // a running division either keeps going or finishes
  a_busy_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start) |=> (busy_r || done_r))
    else $error("divider dropped busy without done");
`endif

endmodule

`default_nettype wire

>>> dv/mertens_table_builder_unit_tb.sv
// testbench for mertens_table_builder_unit: directed and random argument requests,
// results checked against an in-bench mertens table kept by a scoreboard class
// depends on mtb_pkg and the block's rtl (mertens_table_builder_unit, mtb_div)
`timescale 1ns / 1ps

module mertens_table_builder_unit_tb;
  import mtb_pkg::*;

  localparam int TABLE_DEPTH    = TABLE_DEPTH_DEF;
  localparam int ARG_MAX        = (1 << ARG_W) - 1;
  // computed arguments stay small: each one takes one division per term up to n/3
  localparam int GROW_MAX       = 400;
  localparam int RAND_PER_PHASE = 20;
  localparam int QUIET_LIMIT    = 8000;
  localparam int TAIL_CYCLES    = 20;

  typedef struct {
    logic [ARG_W-1:0]        arg;
    logic signed [VAL_W-1:0] val;
    status_t                 st;
  } mertens_result_t;

  // scoreboard: own copy of the table and the next argument to compute
  class mertens_book;
    logic signed [VAL_W-1:0] mertens_tab [TABLE_DEPTH];
    int unsigned             next_n;
    mertens_result_t         due_q [$];
    int unsigned             n_fail, n_computed, n_read, n_rejected;

    function new();
      foreach (mertens_tab[k]) mertens_tab[k] = '0;
      mertens_tab[0] = 1;
      next_n = 2;
      n_fail = 0;
      n_computed = 0;
      n_read = 0;
      n_rejected = 0;
    endfunction

    // M(n) = 1 - sum_{i=2}^{n/3} M(n/i) - (n+1)/2, saturated to the value width
    function logic signed [VAL_W-1:0] mertens_of(int unsigned n);
      longint      acc;
      int unsigned i;
      acc = 0;
      for (i = 2; i <= n / 3; i++) acc += longint'(mertens_tab[(n / i) - 1]);
      acc = 1 - acc - longint'((n + 1) / 2);
      if (acc > VAL_MAX) acc = VAL_MAX;
      if (acc < VAL_MIN) acc = VAL_MIN;
      return acc[VAL_W-1:0];
    endfunction

    // predict the result of an accepted request
    function void note_request(logic [ARG_W-1:0] arg);
      mertens_result_t r;
      int unsigned     n;
      n = 32'(arg);
      r.arg = arg;
      r.val = '0;
      if (n == 0 || n > TABLE_DEPTH || n > next_n) begin
        r.st = ST_ERROR;
        n_rejected++;
      end else if (n < next_n) begin
        r.val = mertens_tab[n - 1];
        r.st = ST_READ;
        n_read++;
      end else begin
        r.val = mertens_of(n);
        mertens_tab[n - 1] = r.val;
        next_n = n + 1;
        r.st = ST_COMPUTED;
        n_computed++;
      end
      due_q.push_back(r);
    endfunction

    // compare a result strobe with the oldest prediction
    function void check_result(logic [ARG_W-1:0] arg, logic signed [VAL_W-1:0] val,
                               logic [ST_W-1:0] st);
      mertens_result_t r;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result arg %0d value %0d status %0d", $time, arg, val, st);
        n_fail++;
        return;
      end
      r = due_q.pop_front();
      if (arg !== r.arg) begin
        $display("%0t: arg_echo mismatch: expected %0d, actual %0d", $time, r.arg, arg);
        n_fail++;
      end
      if (val !== r.val) begin
        $display("%0t: mertens_value mismatch for arg %0d: expected %0d, actual %0d",
                 $time, r.arg, r.val, val);
        n_fail++;
      end
      if (st !== r.st) begin
        $display("%0t: status mismatch for arg %0d: expected %0d, actual %0d",
                 $time, r.arg, r.st, st);
        n_fail++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [ARG_W-1:0]        in_arg_n;
  logic                    out_valid;
  logic [ARG_W-1:0]        out_arg_echo;
  logic signed [VAL_W-1:0] out_mertens_value;
  logic [ST_W-1:0]         out_status;

  mertens_book book;
  int          send_idle_pct;
  int          quiet_cycles;

  mertens_table_builder_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_arg_n         (in_arg_n),
    .out_valid        (out_valid),
    .out_arg_echo     (out_arg_echo),
    .out_mertens_value(out_mertens_value),
    .out_status       (out_status)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) book.check_result(out_arg_echo, out_mertens_value, out_status);
  end

  // watchdog on cycles with neither a request nor a result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, nothing moved for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // issue one request; returns right after the edge that accepts it
  task automatic send_arg(input logic [ARG_W-1:0] n);
    @(negedge clk);
    while (busy || $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    in_arg_n <= n;
    @(posedge clk);
    book.note_request(n);
  endtask

  // hold off until every predicted result has come back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
  endtask

  // random argument: mostly the next one to compute or a read-back, some rejects
  function automatic logic [ARG_W-1:0] pick_arg();
    int unsigned roll;
    int unsigned nxt;
    roll = $urandom_range(99);
    nxt  = book.next_n;
    if (roll < 55 && nxt <= GROW_MAX) return ARG_W'(nxt);
    if (roll < 80) return ARG_W'($urandom_range(nxt - 1, 1));
    if (roll < 88) return ARG_W'(nxt + $urandom_range(4, 1));
    if (roll < 93) return ARG_W'($urandom_range(ARG_MAX, TABLE_DEPTH + 1));
    if (roll < 95) return '0;
    return ARG_W'($urandom_range(ARG_MAX, 0));
  endfunction

  initial begin
    logic [ARG_W-1:0] directed_args [$];
    int               idle_plan [4];
    int               p;

    book          = new();
    rst_n         = 1'b0;
    start         = 1'b0;
    in_arg_n      = '0;
    send_idle_pct = 0;
    quiet_cycles  = 0;
    idle_plan     = '{0, 75, 35, 0};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: preset entry, zero, ahead of order, table edge, beyond table, first computes
    directed_args = '{1, 0, 2, 2, 4, 3, 65536, 65537, ARG_MAX, 4, 5, 6, 7, 8, 9, 10,
                      1, 10, 12, 11, 98304, 0};
    foreach (directed_args[k]) send_arg(directed_args[k]);
    drain_results();

    // random phases with different sender idling, drained in between
    for (p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      repeat (RAND_PER_PHASE) send_arg(pick_arg());
      drain_results();
    end

    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d computed values (table built up to M(%0d)), %0d read-backs,",
             book.n_computed, book.next_n - 1, book.n_read);
    $display("and %0d rejected arguments (zero, ahead of order, beyond the table)",
             book.n_rejected);
    if (book.n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/mtb_pkg.sv
hw/rtl/mtb_div.sv
hw/rtl/mertens_table_builder_unit.sv
dv/mertens_table_builder_unit_tb.sv
